// ----- src/disjoint_set_union_find_defines.svh -----
// Assertion macros shared by the disjoint-set block.
`ifndef DISJOINT_SET_UNION_FIND_DEFINES_SVH
`define DISJOINT_SET_UNION_FIND_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsu assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsu assertion failed");

`endif

// ----- src/dsu_pkg.sv -----
package dsu_pkg;

    localparam int NUM_VERTICES_DEF = 64;
    localparam int VERTEX_W         = 7;
    localparam int SET_INDEX_W      = 6;

    localparam logic CMD_FIND  = 1'b0;
    localparam logic CMD_UNION = 1'b1;

    typedef struct packed {
        logic                command;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
    } req_item_t;

    typedef struct packed {
        logic [SET_INDEX_W-1:0] set_index;
        logic                   error;
        logic                   merged;
    } rsp_item_t;

endpackage

// ----- src/dsu_mem.sv -----
module dsu_mem #(
    parameter int NUM_VERTICES = 64
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [$clog2(NUM_VERTICES)-1:0] wr_addr,
    input  logic [$clog2(NUM_VERTICES)-1:0] wr_data,
    input  logic [$clog2(NUM_VERTICES)-1:0] rd_addr,
    output logic [$clog2(NUM_VERTICES)-1:0] rd_data
);
    localparam int AddrW = $clog2(NUM_VERTICES);

    // Set index of each vertex, one entry per vertex.
    logic [AddrW-1:0] mem [NUM_VERTICES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- src/dsu_ctrl.sv -----
`include "disjoint_set_union_find_defines.svh"

module dsu_ctrl #(
    parameter int NUM_VERTICES = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  dsu_pkg::req_item_t              req,
    input  logic                            slot_free,
    output logic                            done,
    output dsu_pkg::rsp_item_t              result,
    output logic                            wr_en,
    output logic [$clog2(NUM_VERTICES)-1:0] wr_addr,
    output logic [$clog2(NUM_VERTICES)-1:0] wr_data,
    output logic [$clog2(NUM_VERTICES)-1:0] rd_addr,
    input  logic [$clog2(NUM_VERTICES)-1:0] rd_data
);
    import dsu_pkg::*;

    localparam int AddrW = $clog2(NUM_VERTICES);
    localparam logic [AddrW-1:0] LastAddr = AddrW'(NUM_VERTICES - 1);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_RD_A   = 3'd2;
    localparam logic [2:0] ST_RD_B   = 3'd3;
    localparam logic [2:0] ST_SWEEP  = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [AddrW-1:0] cnt_reg, cnt_next;
    logic             cmd_reg, cmd_next;
    logic [AddrW-1:0] vb_addr_reg, vb_addr_next;
    logic [AddrW-1:0] sa_reg, sa_next;
    logic [AddrW-1:0] sb_reg, sb_next;
    rsp_item_t        res_reg, res_next;

    logic             accept;
    logic             va_ok;
    logic             vb_ok;
    logic [VERTEX_W-1:0]       va_m1;
    logic [VERTEX_W-1:0]       vb_m1;
    logic [AddrW+VERTEX_W-1:0] va_ext;
    logic [AddrW+VERTEX_W-1:0] vb_ext;

    // Set index reported on the port: low bits of the stored index.
    function automatic logic [SET_INDEX_W-1:0] to_set_index(input logic [AddrW-1:0] s);
        logic [AddrW+SET_INDEX_W-1:0] wide;
        wide = {{SET_INDEX_W{1'b0}}, s};
        return wide[SET_INDEX_W-1:0];
    endfunction

    assign accept = req_valid && req_ready;
    assign va_ok  = (req.vertex_a != '0) && (32'(req.vertex_a) <= 32'(NUM_VERTICES));
    assign vb_ok  = (req.vertex_b != '0) && (32'(req.vertex_b) <= 32'(NUM_VERTICES));
    assign va_m1  = req.vertex_a - VERTEX_W'(1);
    assign vb_m1  = req.vertex_b - VERTEX_W'(1);
    assign va_ext = {{AddrW{1'b0}}, va_m1};
    assign vb_ext = {{AddrW{1'b0}}, vb_m1};

    assign req_ready = (state_reg == ST_IDLE);
    assign result    = res_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd_next     = cmd_reg;
        vb_addr_next = vb_addr_reg;
        sa_next      = sa_reg;
        sb_next      = sb_reg;
        res_next     = res_reg;
        done         = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = cnt_reg;
        wr_data      = cnt_reg;
        rd_addr      = cnt_reg + AddrW'(1);

        unique case (state_reg)
            ST_INIT:
            begin
                wr_en = 1'b1;
                if (cnt_reg == LastAddr)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AddrW'(1);
                end
            end
            ST_IDLE:
            begin
                rd_addr = va_ext[AddrW-1:0];
                if (accept)
                begin
                    cmd_next     = req.command;
                    vb_addr_next = vb_ext[AddrW-1:0];
                    if (!va_ok || (req.command == CMD_UNION && !vb_ok))
                    begin
                        res_next   = '{set_index: '0, error: 1'b1, merged: 1'b0};
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_RD_A;
                    end
                end
            end
            ST_RD_A:
            begin
                sa_next = rd_data;
                rd_addr = vb_addr_reg;
                if (cmd_reg == CMD_FIND)
                begin
                    res_next   = '{set_index: to_set_index(rd_data), error: 1'b0, merged: 1'b0};
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_RD_B;
                end
            end
            ST_RD_B:
            begin
                rd_addr = '0;
                if (rd_data == sa_reg)
                begin
                    res_next   = '{set_index: to_set_index(sa_reg), error: 1'b0, merged: 1'b0};
                    state_next = ST_RESULT;
                end
                else
                begin
                    sb_next    = rd_data;
                    cnt_next   = '0;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                // rd_data holds entry cnt_reg; the next entry is read meanwhile,
                // so a write never meets a read of the same entry.
                wr_data = sa_reg;
                wr_en   = (rd_data == sb_reg);
                if (cnt_reg == LastAddr)
                begin
                    cnt_next   = '0;
                    res_next   = '{set_index: to_set_index(sa_reg), error: 1'b0, merged: 1'b1};
                    state_next = ST_RESULT;
                end
                else
                begin
                    cnt_next = cnt_reg + AddrW'(1);
                end
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        vb_addr_reg <= vb_addr_next;
        sa_reg      <= sa_next;
        sb_reg      <= sb_next;
        res_reg     <= res_next;
    end

    `DSU_ASSERT_NEXT(a_sweep_step, state_reg == ST_SWEEP && cnt_reg != LastAddr,
        state_reg == ST_SWEEP && cnt_reg == $past(cnt_reg) + AddrW'(1))
    `DSU_ASSERT_SAME(a_write_source, wr_en, state_reg == ST_INIT || state_reg == ST_SWEEP)
    `DSU_ASSERT_SAME(a_done_slot, done, slot_free && state_reg == ST_RESULT)
    `DSU_ASSERT_SAME(a_merge_clean, done && result.merged, !result.error)

endmodule

// ----- src/disjoint_set_union_find.sv -----
// Disjoint-set (union-find) block, quick-find scheme. Vertices 1..NUM_VERTICES
// are kept in sets through a table that gives each vertex its set index; after
// reset set i holds only vertex i+1. A find beat returns the set of vertex_a. A
// union beat moves every member of vertex_b's set into vertex_a's set and
// returns vertex_a's set, with merged high when two different sets were joined.
// A vertex outside 1..NUM_VERTICES returns error high, set_index zero, and leaves
// the table untouched; vertex_b is not checked on a find. After reset the block
// fills the table with one entry per vertex and takes no request beat until
// that pass is done. One item is worked on at a time. A rejected item goes
// straight to the response step; a find reads vertex_a's entry; a union also
// reads vertex_b's entry and, if both lie in one set, ends there; a real union
// then walks every table entry through the single read port of the table
// memory, one entry per cycle, and relabels the members of vertex_b's set.
// The next request beat is taken in the cycle after a result is loaded into
// the response register, even if that result has not yet been taken.
module disjoint_set_union_find #(
    parameter int NUM_VERTICES = dsu_pkg::NUM_VERTICES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  dsu_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output dsu_pkg::rsp_item_t rsp
);
    import dsu_pkg::*;

    localparam int AddrW = $clog2(NUM_VERTICES);

    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [AddrW-1:0] wr_data;
    logic [AddrW-1:0] rd_addr;
    logic [AddrW-1:0] rd_data;

    logic      done;
    logic      slot_free;
    rsp_item_t result;

    // Response register: it separates the controller from the consumer, so a
    // finished result can wait here while the next request is being worked on.
    logic      rsp_valid_reg, rsp_valid_next;
    rsp_item_t rsp_reg;

    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (done)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    dsu_ctrl #(
        .NUM_VERTICES(NUM_VERTICES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .slot_free(slot_free),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    // Set-index table, one entry per vertex, one write and one read per cycle.
    dsu_mem #(
        .NUM_VERTICES(NUM_VERTICES)
    ) u_mem (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

endmodule

// ----- dv/dsu_partition_checker.sv -----
// Watches both channels of the disjoint-set block, keeps its own copy of the
// vertex-to-set table, and compares every response beat with the answer due.
module dsu_partition_checker #(
    parameter int NUM_VERTICES = dsu_pkg::NUM_VERTICES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  dsu_pkg::req_item_t req,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  dsu_pkg::rsp_item_t rsp,
    output int                 fail_count,
    output int                 pending,
    output int                 joins
);
    timeunit 1ns;
    timeprecision 1ps;

    import dsu_pkg::*;

    logic [SET_INDEX_W-1:0] vertex_set [NUM_VERTICES];
    rsp_item_t              answers_due [$];
    int                     n_fail;
    int                     n_joins;

    function automatic bit vertex_in_range(input logic [VERTEX_W-1:0] v);
        return v >= 1 && v <= NUM_VERTICES;
    endfunction

    // Quick-find: a real union relabels every vertex of B's set to A's set.
    function automatic rsp_item_t apply_set_op(input req_item_t item);
        rsp_item_t              answer;
        logic [SET_INDEX_W-1:0] set_a;
        logic [SET_INDEX_W-1:0] set_b;
        answer = '0;
        if (!vertex_in_range(item.vertex_a) ||
            (item.command == CMD_UNION && !vertex_in_range(item.vertex_b)))
        begin
            answer.error = 1'b1;
            return answer;
        end
        set_a = vertex_set[item.vertex_a - 1];
        if (item.command == CMD_UNION)
        begin
            set_b = vertex_set[item.vertex_b - 1];
            if (set_a != set_b)
            begin
                for (int i = 0; i < NUM_VERTICES; i++)
                begin
                    if (vertex_set[i] == set_b)
                        vertex_set[i] = set_a;
                end
                answer.merged = 1'b1;
            end
        end
        answer.set_index = set_a;
        return answer;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_VERTICES; i++)
                vertex_set[i] = SET_INDEX_W'(i);
            answers_due.delete();
            n_fail  = 0;
            n_joins = 0;
        end
        else
        begin
            // A response never belongs to a request taken in the same cycle,
            // so the compare comes before the new request is predicted.
            if (rsp_valid && rsp_ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("response beat with nothing outstanding: %s %0d %0b %0b",
                           "set_index error merged", rsp.set_index, rsp.error,
                           rsp.merged);
                    n_fail++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp.set_index !== want.set_index)
                    begin
                        $error("set_index: expected %0d, actual %0d",
                               want.set_index, rsp.set_index);
                        n_fail++;
                    end
                    if (rsp.error !== want.error)
                    begin
                        $error("error: expected %0b, actual %0b", want.error, rsp.error);
                        n_fail++;
                    end
                    if (rsp.merged !== want.merged)
                    begin
                        $error("merged: expected %0b, actual %0b", want.merged, rsp.merged);
                        n_fail++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                want = apply_set_op(req);
                if (want.merged)
                    n_joins++;
                answers_due.push_back(want);
            end
        end
        fail_count <= n_fail;
        pending    <= answers_due.size();
        joins      <= n_joins;
    end

endmodule

// ----- dv/tb.sv -----
// Top of the disjoint-set testbench. It makes the clock and reset, drives the
// request channel, paces the response channel, and gives the verdict. All
// prediction and comparison live in the checker instantiated beside the block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dsu_pkg::*;

    localparam int NUM_VERTICES  = NUM_VERTICES_DEF;
    localparam int RANDOM_ITEMS  = 2000;
    // Long receiver hold-off, taken once, so that the block fills up and
    // has to refuse request beats for a good while.
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 300;
    // The limit lies well above the slowest correct stretch without a beat.
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_VERTEX    = (1 << VERTEX_W) - 1;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp;

    int fail_count;
    int pending;
    int joins;

    int sent_finds;
    int sent_unions;
    int sent_bad;
    int idle_cycles;
    bit tx_calm;
    bit rx_calm;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    disjoint_set_union_find #(
        .NUM_VERTICES(NUM_VERTICES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    dsu_partition_checker #(
        .NUM_VERTICES(NUM_VERTICES)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .fail_count(fail_count),
        .pending   (pending),
        .joins     (joins)
    );

    // A vertex number the block must reject: zero or anything past the last
    // vertex, up to the all-ones value of the field.
    function automatic int bad_vertex();
        return $urandom_range(0, 1) ? 0 : $urandom_range(NUM_VERTICES + 1, MAX_VERTEX);
    endfunction

    // Mostly well-formed finds and unions on random vertices, with a share of
    // beats that carry an out-of-range operand. On a find, vertex_b is left
    // fully random since the block must ignore it.
    function automatic req_item_t random_request();
        req_item_t item;
        int        pick;
        pick          = $urandom_range(0, 99);
        item.command  = (pick < 45) ? CMD_UNION : CMD_FIND;
        item.vertex_a = VERTEX_W'($urandom_range(1, NUM_VERTICES));
        item.vertex_b = (item.command == CMD_UNION) ?
                        VERTEX_W'($urandom_range(1, NUM_VERTICES)) :
                        VERTEX_W'($urandom_range(0, MAX_VERTEX));
        if (pick % 8 == 0)
            item.vertex_a = VERTEX_W'(bad_vertex());
        else if (pick % 8 == 1 && item.command == CMD_UNION)
            item.vertex_b = VERTEX_W'(bad_vertex());
        return item;
    endfunction

    // Offers one request beat and returns at the edge that accepts it. The
    // caller is always at a clock edge, so valid gets a single assignment in
    // this time step: lowered for a gap, or kept high with the new payload.
    task automatic send_request(input req_item_t item);
        int gap;
        if ((sent_finds + sent_unions) % 100 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (item.command == CMD_UNION)
            sent_unions++;
        else
            sent_finds++;
        if (item.vertex_a < 1 || item.vertex_a > NUM_VERTICES ||
            (item.command == CMD_UNION &&
             (item.vertex_b < 1 || item.vertex_b > NUM_VERTICES)))
            sent_bad++;
    endtask

    task automatic send_fields(input logic cmd, input int a, input int b);
        req_item_t item;
        item.command  = cmd;
        item.vertex_a = VERTEX_W'(a);
        item.vertex_b = VERTEX_W'(b);
        send_request(item);
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        sent_finds  = 0;
        sent_unions = 0;
        sent_bad    = 0;
        tx_calm     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Finds at both ends of the vertex range, with vertex_b
        // out of range to show it is ignored on a find.
        send_fields(CMD_FIND, 1, 0);
        send_fields(CMD_FIND, NUM_VERTICES, MAX_VERTEX);
        // Rejected operands: zero, one past the end, and all ones.
        send_fields(CMD_FIND, 0, 1);
        send_fields(CMD_FIND, NUM_VERTICES + 1, 1);
        send_fields(CMD_FIND, MAX_VERTEX, 1);
        send_fields(CMD_UNION, 0, 5);
        send_fields(CMD_UNION, 5, NUM_VERTICES + 1);
        send_fields(CMD_UNION, MAX_VERTEX, MAX_VERTEX);
        // Real unions and unions within one set, including a vertex with itself.
        send_fields(CMD_UNION, 1, 2);
        send_fields(CMD_UNION, 2, 1);
        send_fields(CMD_UNION, NUM_VERTICES, NUM_VERTICES - 1);
        send_fields(CMD_UNION, 1, NUM_VERTICES);
        send_fields(CMD_FIND, NUM_VERTICES - 1, 0);
        send_fields(CMD_UNION, 3, 3);
        // Alternating bit patterns on both vertex fields.
        send_fields(CMD_UNION, 42, 85);
        send_fields(CMD_FIND, 42, 85);
        send_fields(CMD_UNION, 85, 42);
        // A set of several members moved as a whole into another set.
        send_fields(CMD_UNION, 33, 1);
        send_fields(CMD_FIND, NUM_VERTICES, 0);
        send_fields(CMD_UNION, NUM_VERTICES, 32);
        send_fields(CMD_FIND, 2, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_request(random_request());
        req_valid <= 1'b0;

        // One edge lets the checker count the last accepted beat as pending.
        @(posedge clk);
        // Drain, then give the block time to show any stray response beat.
        while (pending != 0)
            @(posedge clk);
        repeat (NUM_VERTICES + 8) @(posedge clk);

        $display("Run covered %0d finds and %0d unions, %0d of them joining two sets,",
                 sent_finds, sent_unions, joins);
        $display("with %0d beats rejected for an out-of-range vertex.", sent_bad);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Response pacing. Each beat draws its own stall, with calm stretches of
    // no stall at all, and one long hold-off while the sender keeps going.
    initial
    begin : receiver
        int stall;
        int taken;
        rsp_ready <= 1'b0;
        rx_calm   = 1'b0;
        taken     = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (taken % 64 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (taken == HOLD_AT)
                stall = HOLD_CYCLES;
            else
                stall = rx_calm ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            taken++;
        end
    end

    // Watchdog: counts cycles in which neither channel moves a beat. The
    // clearing pass after reset is well inside the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no beat on either channel for %0d cycles.", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
